FILE: src/ihsp_pkg.sv
package ihsp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [30:0] width;
		logic [30:0] height;
	} out_item_t;

	typedef enum logic [3:0] {
		PH_SIG     = 4'd0,
		PH_SEEK    = 4'd1,
		PH_FILL    = 4'd2,
		PH_LEN_HI  = 4'd3,
		PH_LEN_LO  = 4'd4,
		PH_SKIP    = 4'd5,
		PH_FRAME   = 4'd6
	} phase_t;

	localparam logic [1:0] FMT_JPEG = 2'd0;
	localparam logic [1:0] FMT_BMP  = 2'd1;
	localparam logic [1:0] FMT_PNG  = 2'd2;

	localparam logic [7:0] JPEG_MARK   = 8'hFF;
	localparam logic [7:0] JPEG_SOI    = 8'hD8;
	localparam logic [7:0] JPEG_SOF0   = 8'hC0;
	localparam logic [7:0] JPEG_SOF15  = 8'hCF;
	localparam logic [7:0] JPEG_DHT    = 8'hC4;
	localparam logic [7:0] JPEG_JPG    = 8'hC8;
	localparam logic [7:0] JPEG_DAC    = 8'hCC;
	localparam logic [7:0] BMP_SIG0    = 8'h42;
	localparam logic [7:0] BMP_SIG1    = 8'h4D;

	localparam logic [4:0] POS_MAX       = 5'd31;
	localparam logic [4:0] BMP_W_FIRST   = 5'd18;
	localparam logic [4:0] BMP_W_LAST    = 5'd21;
	localparam logic [4:0] BMP_H_FIRST   = 5'd22;
	localparam logic [4:0] BMP_H_LAST    = 5'd25;
	localparam logic [4:0] PNG_SIG_LEN   = 5'd8;
	localparam logic [4:0] PNG_W_FIRST   = 5'd16;
	localparam logic [4:0] PNG_W_LAST    = 5'd19;
	localparam logic [4:0] PNG_H_FIRST   = 5'd20;
	localparam logic [4:0] PNG_H_LAST    = 5'd23;

	localparam logic [2:0] FR_H_HI = 3'd3;
	localparam logic [2:0] FR_H_LO = 3'd4;
	localparam logic [2:0] FR_W_HI = 3'd5;
	localparam logic [2:0] FR_W_LO = 3'd6;

	function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h89;
			3'd1: r = 8'h50;
			3'd2: r = 8'h4E;
			3'd3: r = 8'h47;
			3'd4: r = 8'h0D;
			3'd5: r = 8'h0A;
			3'd6: r = 8'h1A;
			3'd7: r = 8'h0A;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic positive31(input logic [31:0] v);
		return (v != 32'd0) && !v[31];
	endfunction

	function automatic logic is_frame_marker(input logic [7:0] m);
		return (m >= JPEG_SOF0) && (m <= JPEG_SOF15) && (m != JPEG_DHT)
			&& (m != JPEG_JPG) && (m != JPEG_DAC);
	endfunction

endpackage

FILE: src/image_header_size_parser.sv
// A result item is loaded into the output register when its last byte, held in the input register, is processed.
// Throughput: one byte item per cycle while in_stall is low; the parse state loop updates once per byte.
// The input stalls only when a last byte waits for an output register that is full and stalled.
// Reset clears the format register to JPEG and the whole parse state; a format write also
// restarts the parse, so the next byte is taken as the first byte of a new image.
module image_header_size_parser
	import ihsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [1:0] cfg_wdata
);

	logic [1:0]  format_q;
	phase_t      phase_q, n_phase;
	logic [4:0]  pos_q, n_pos;
	logic [15:0] skip_q, n_skip;
	logic [7:0]  len_hi_q, n_len_hi;
	logic [2:0]  frame_q, n_frame;
	logic [31:0] width_q, n_width;
	logic [31:0] height_q, n_height;
	logic        decided_q, n_decided;
	logic        found_q, n_found;

	in_item_t  data_s1;
	logic      valid_s1;
	logic      out_valid_q;
	out_item_t out_q;

	logic      out_free;
	logic      proc_s1;
	logic      in_accept;
	logic      emit;
	out_item_t res;

	assign out_free  = !out_valid_q || !out_stall;
	assign proc_s1   = valid_s1 && (!data_s1.last_byte || out_free);
	assign in_stall  = valid_s1 && !proc_s1;
	assign in_accept = in_valid && !in_stall;
	assign emit      = proc_s1 && data_s1.last_byte;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		logic [7:0]  b;
		logic [4:0]  boff;
		logic [15:0] seg;
		logic [15:0] skip_dec;
		logic [31:0] hraw;
		logic [31:0] wnew;
		b         = data_s1.data_byte;
		boff      = 5'd0;
		seg       = {len_hi_q, b};
		skip_dec  = skip_q - 16'd1;
		hraw      = height_q;
		wnew      = width_q;
		n_phase   = phase_q;
		n_pos     = pos_q;
		n_skip    = skip_q;
		n_len_hi  = len_hi_q;
		n_frame   = frame_q;
		n_width   = width_q;
		n_height  = height_q;
		n_decided = decided_q;
		n_found   = found_q;
		res       = '0;
		if (proc_s1 && !decided_q) begin
			case (format_q)
				FMT_JPEG: begin
					case (phase_q)
						PH_SIG: begin
							if ((pos_q == 5'd0 && b != JPEG_MARK)
								|| (pos_q == 5'd1 && b != JPEG_SOI)) begin
								n_decided = 1'b1;
								n_found   = 1'b0;
							end else if (pos_q == 5'd1) begin
								n_phase = PH_SEEK;
							end
						end
						PH_SEEK: begin
							if (b == JPEG_MARK) n_phase = PH_FILL;
						end
						PH_FILL: begin
							if (b != JPEG_MARK) begin
								if (is_frame_marker(b)) begin
									n_phase = PH_FRAME;
									n_frame = 3'd0;
								end else begin
									n_phase = PH_LEN_HI;
								end
							end
						end
						PH_LEN_HI: begin
							n_len_hi = b;
							n_phase  = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							if (seg < 16'd2) begin
								n_decided = 1'b1;
								n_found   = 1'b0;
							end else begin
								n_skip  = seg - 16'd2;
								n_phase = (seg == 16'd2) ? PH_SEEK : PH_SKIP;
							end
						end
						PH_SKIP: begin
							n_skip = skip_dec;
							if (skip_dec == 16'd0) n_phase = PH_SEEK;
						end
						PH_FRAME: begin
							case (frame_q)
								FR_H_HI: n_height = {16'd0, b, 8'd0};
								FR_H_LO: n_height = height_q | {24'd0, b};
								FR_W_HI: n_width = {16'd0, b, 8'd0};
								FR_W_LO: begin
									wnew      = width_q | {24'd0, b};
									n_width   = wnew;
									n_decided = 1'b1;
									n_found   = (wnew != 32'd0) && (height_q != 32'd0);
								end
								default: ;
							endcase
							n_frame = frame_q + 3'd1;
						end
						default: begin
							n_decided = 1'b1;
							n_found   = 1'b0;
						end
					endcase
				end
				FMT_BMP: begin
					if ((pos_q == 5'd0 && b != BMP_SIG0) || (pos_q == 5'd1 && b != BMP_SIG1)) begin
						n_decided = 1'b1;
						n_found   = 1'b0;
					end else if (pos_q >= BMP_W_FIRST && pos_q <= BMP_W_LAST) begin
						boff = pos_q - BMP_W_FIRST;
						n_width[{boff[1:0], 3'b000} +: 8] = b;
					end else if (pos_q >= BMP_H_FIRST && pos_q <= BMP_H_LAST) begin
						boff = pos_q - BMP_H_FIRST;
						hraw[{boff[1:0], 3'b000} +: 8] = b;
						n_height = hraw;
						if (pos_q == BMP_H_LAST) begin
							// A top-down bitmap stores a negative height.
							if (hraw[31]) n_height = 32'd0 - hraw;
							n_decided = 1'b1;
							n_found   = positive31(width_q) && positive31(n_height);
						end
					end
				end
				FMT_PNG: begin
					if (pos_q < PNG_SIG_LEN) begin
						if (b != png_sig_byte(pos_q[2:0])) begin
							n_decided = 1'b1;
							n_found   = 1'b0;
						end
					end else if (pos_q >= PNG_W_FIRST && pos_q <= PNG_W_LAST) begin
						n_width = {width_q[23:0], b};
					end else if (pos_q >= PNG_H_FIRST && pos_q <= PNG_H_LAST) begin
						hraw     = {height_q[23:0], b};
						n_height = hraw;
						if (pos_q == PNG_H_LAST) begin
							n_decided = 1'b1;
							n_found   = positive31(width_q) && positive31(hraw);
						end
					end
				end
				default: begin
					n_decided = 1'b1;
					n_found   = 1'b0;
				end
			endcase
			if (pos_q != POS_MAX) n_pos = pos_q + 5'd1;
		end
		if (emit) begin
			res.ok     = n_decided && n_found;
			res.width  = res.ok ? n_width[30:0] : 31'd0;
			res.height = res.ok ? n_height[30:0] : 31'd0;
			n_phase    = PH_SIG;
			n_pos      = 5'd0;
			n_skip     = 16'd0;
			n_len_hi   = 8'd0;
			n_frame    = 3'd0;
			n_width    = 32'd0;
			n_height   = 32'd0;
			n_decided  = 1'b0;
			n_found    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q  <= FMT_JPEG;
			phase_q   <= PH_SIG;
			pos_q     <= 5'd0;
			skip_q    <= 16'd0;
			len_hi_q  <= 8'd0;
			frame_q   <= 3'd0;
			width_q   <= 32'd0;
			height_q  <= 32'd0;
			decided_q <= 1'b0;
			found_q   <= 1'b0;
		end else if (cfg_we) begin
			format_q  <= cfg_wdata;
			phase_q   <= PH_SIG;
			pos_q     <= 5'd0;
			skip_q    <= 16'd0;
			len_hi_q  <= 8'd0;
			frame_q   <= 3'd0;
			width_q   <= 32'd0;
			height_q  <= 32'd0;
			decided_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			phase_q   <= n_phase;
			pos_q     <= n_pos;
			skip_q    <= n_skip;
			len_hi_q  <= n_len_hi;
			frame_q   <= n_frame;
			width_q   <= n_width;
			height_q  <= n_height;
			decided_q <= n_decided;
			found_q   <= n_found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (proc_s1) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) data_s1 <= in_data;
		if (emit) out_q <= res;
	end

endmodule
